// ===== design/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared types and constants for the front end, job queue and pixel stepper.
// ----------------------------------------------------------------------------
package blr_pkg;

  // Widest coordinate that the block supports; narrower builds zero-extend.
  localparam int COORD_MAX_BITS = 6;

  // Job queue between the classifier and the stepper.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_MAX_BITS-1:0] coord_t;

  // One classified line, in major/minor axis form.
  typedef struct packed {
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    coord_t dx;
    coord_t dy;
    logic   minor_down;
    logic   steep;
  } blr_job_t;

endpackage

// ===== design/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Turns two-endpoint line commands into a stream of pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken on a rising edge with start high and busy
//   low; start_x/start_y and end_x/end_y give the endpoints.
//   Pixels leave one per cycle on pixel_x/pixel_y with pixel_valid high for a
//   single cycle each; last_pixel marks the final pixel of a line. The far
//   endpoint is not drawn and a single-point line produces no pixels.
//   pixel_on is the inverse of the draw_color register, written through the
//   cfg_valid/cfg_ready/cfg_data channel (cfg_ready is always high); the user
//   must write it only while the block is idle; the block does not enforce it.
//   A taken command is registered in the job queue, then loaded into the
//   stepper's line registers, then registered onto the pixel outputs. The
//   stepper walks a line of N pixels (at most 2^COORD_BITS - 1) one pixel per
//   cycle. A two-entry job queue lets commands be taken while a line is being
//   drawn, so consecutive lines stream without gaps; busy is high when it is
//   full. The receiver cannot stall the pixel stream.
//   Reset (rst, synchronous) empties the queue, stops the stepper and sets
//   draw_color to 0.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  output logic                  pixel_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  pixel_on,
  output logic                  last_pixel
);
  import blr_pkg::*;

  logic     draw_color;
  logic     accept;
  logic     push;
  blr_job_t push_job;
  logic     queue_full;
  logic     job_valid;
  blr_job_t head_job;
  logic     pop;

  assign cfg_ready = 1'b1;
  assign busy      = queue_full;
  assign accept    = start && !busy;

  // Color register.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      draw_color <= cfg_data;
    end
  end

  // Command classification.
  blr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .accept  (accept),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .push    (push),
    .job     (push_job)
  );

  // Job queue.
  blr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (job_valid),
    .head      (head_job)
  );

  // Pixel stepper.
  blr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (head_job),
    .draw_color  (draw_color),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_on    (pixel_on),
    .last_pixel  (last_pixel)
  );

endmodule

// ===== design/blr_front.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Classifies an accepted line command and turns it into a stepper job.
// ----------------------------------------------------------------------------
module blr_front #(
  parameter int COORD_BITS = 6
) (
  input  logic                  accept,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  push,
  output blr_pkg::blr_job_t     job
);
  import blr_pkg::*;

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  steep;
  logic [COORD_BITS-1:0] a1, b1, a2, b2;
  logic [COORD_BITS-1:0] major_lo, major_hi, minor_lo, minor_hi;

  // Absolute deltas decide whether the axes are swapped.
  assign adx   = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
  assign ady   = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
  assign steep = (ady > adx);

  // Map the endpoints onto the major and minor axes.
  assign a1 = steep ? start_y : start_x;
  assign b1 = steep ? start_x : start_y;
  assign a2 = steep ? end_y   : end_x;
  assign b2 = steep ? end_x   : end_y;

  // Order the endpoints so that the major coordinate rises.
  always_comb begin
    if (a1 > a2) begin
      major_lo = a2;
      major_hi = a1;
      minor_lo = b2;
      minor_hi = b1;
    end else begin
      major_lo = a1;
      major_hi = a2;
      minor_lo = b1;
      minor_hi = b2;
    end
  end

  // Horizontal and vertical lines fall out of the same form with dy of zero.
  always_comb begin
    job.major_pos  = coord_t'(major_lo);
    job.major_end  = coord_t'(major_hi);
    job.minor_pos  = coord_t'(minor_lo);
    job.dx         = coord_t'(major_hi - major_lo);
    job.dy         = coord_t'(steep ? adx : ady);
    job.minor_down = (minor_lo > minor_hi);
    job.steep      = steep;
  end

  // A single point produces no pixels, so it never enters the queue.
  assign push = accept && (major_hi != major_lo);

endmodule

// ===== design/blr_queue.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer job queue
// Short FIFO of classified lines between the front end and the stepper.
// ----------------------------------------------------------------------------
module blr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  blr_pkg::blr_job_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output blr_pkg::blr_job_t head
);
  import blr_pkg::*;

  blr_job_t               entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/blr_back.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer stepper
// Walks one queued line a pixel per cycle with the Bresenham error term.
// ----------------------------------------------------------------------------
module blr_back #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  input  blr_pkg::blr_job_t     job,
  input  logic                  draw_color,
  output logic                  pop,
  output logic                  pixel_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  pixel_on,
  output logic                  last_pixel
);
  import blr_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 1;

  logic                       active;
  logic [COORD_BITS-1:0]      major_pos;
  logic [COORD_BITS-1:0]      major_end;
  logic [COORD_BITS-1:0]      minor_pos;
  logic [COORD_BITS-1:0]      dx;
  logic [COORD_BITS-1:0]      dy;
  logic                       minor_down;
  logic                       steep;
  logic signed [ERR_BITS-1:0] err;

  logic                       at_last;
  logic                       load;
  logic signed [ERR_BITS-1:0] err_sub;
  logic signed [ERR_BITS-1:0] err_next;
  logic                       minor_step;
  logic [COORD_BITS-1:0]      job_dx;

  // The pixel being emitted is the last one when the next major step hits the end.
  assign at_last = (major_pos + 1'b1) == major_end;

  // Take the next job as soon as the current line finishes.
  assign load = job_valid && (!active || at_last);
  assign pop  = load;

  // Error update for the step after the current pixel.
  assign err_sub    = err - $signed({1'b0, dy});
  assign minor_step = err_sub[ERR_BITS-1];
  assign err_next   = minor_step ? (err_sub + $signed({1'b0, dx})) : err_sub;

  assign job_dx = job.dx[COORD_BITS-1:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= active;
      if (load) begin
        active <= 1'b1;
      end else if (active && at_last) begin
        active <= 1'b0;
      end
    end
  end

  // Line registers and output pixel.
  always_ff @(posedge clk) begin
    if (active) begin
      pixel_x    <= steep ? minor_pos : major_pos;
      pixel_y    <= steep ? major_pos : minor_pos;
      pixel_on   <= ~draw_color;
      last_pixel <= at_last;
    end
    if (load) begin
      major_pos  <= job.major_pos[COORD_BITS-1:0];
      major_end  <= job.major_end[COORD_BITS-1:0];
      minor_pos  <= job.minor_pos[COORD_BITS-1:0];
      dx         <= job_dx;
      dy         <= job.dy[COORD_BITS-1:0];
      minor_down <= job.minor_down;
      steep      <= job.steep;
      err        <= $signed({1'b0, job_dx >> 1});
    end else if (active) begin
      major_pos <= major_pos + 1'b1;
      err       <= err_next;
      if (minor_step) begin
        minor_pos <= minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
      end
    end
  end

endmodule

// ===== tb/line_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel checker
// Watches the command, color and pixel channels of the line rasterizer. It
// works out the pixels of every accepted line, keeps them in drawing order
// and compares each pixel that the block emits with the oldest one due.
// ----------------------------------------------------------------------------
module line_pixel_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  blr_pkg::coord_t start_x,
  input  blr_pkg::coord_t start_y,
  input  blr_pkg::coord_t end_x,
  input  blr_pkg::coord_t end_y,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_data,
  input  logic            pixel_valid,
  input  blr_pkg::coord_t pixel_x,
  input  blr_pkg::coord_t pixel_y,
  input  logic            pixel_on,
  input  logic            last_pixel,
  output int              mismatch_count,
  output int              pending_pixels,
  output int              lines_accepted,
  output int              pixels_checked
);
  import blr_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   on;
    logic   last;
  } pixel_t;

  // Pixels still to come, oldest first.
  pixel_t pixels_due[$];
  logic   draw_color;

  function automatic void add_pixel(int x, int y);
    pixel_t p;
    p.x    = coord_t'(x);
    p.y    = coord_t'(y);
    p.on   = ~draw_color;
    p.last = 1'b0;
    pixels_due.push_back(p);
  endfunction

  // Works out every pixel of one line command, far endpoint excluded.
  task automatic rasterize_line(input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey);
    int     x1, y1, x2, y2, t;
    int     adx, ady, dx, dy, err, ystep, y, x;
    int     first;
    bit     steep;
    pixel_t tail;
    first = pixels_due.size();
    x1 = sx;
    y1 = sy;
    x2 = ex;
    y2 = ey;
    if (x1 == x2) begin
      // Vertical lines run top first.
      for (int i = (y1 < y2 ? y1 : y2); i < (y1 < y2 ? y2 : y1); i++) begin
        add_pixel(x1, i);
      end
    end else if (y1 == y2) begin
      // Horizontal lines run left first.
      for (int i = (x1 < x2 ? x1 : x2); i < (x1 < x2 ? x2 : x1); i++) begin
        add_pixel(i, y1);
      end
    end else begin
      adx   = x2 > x1 ? x2 - x1 : x1 - x2;
      ady   = y2 > y1 ? y2 - y1 : y1 - y2;
      steep = ady > adx;
      // Walk along the major axis with the major coordinate rising.
      if (steep) begin
        t = x1; x1 = y1; y1 = t;
        t = x2; x2 = y2; y2 = t;
      end
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx    = x2 - x1;
      dy    = y2 > y1 ? y2 - y1 : y1 - y2;
      err   = dx / 2;
      ystep = y1 < y2 ? 1 : -1;
      y     = y1;
      for (x = x1; x < x2; x++) begin
        if (steep) begin
          add_pixel(y, x);
        end else begin
          add_pixel(x, y);
        end
        err -= dy;
        if (err < 0) begin
          y   += ystep;
          err += dx;
        end
      end
    end
    // The final pixel of a line carries the last marker.
    if (pixels_due.size() > first) begin
      tail      = pixels_due.pop_back();
      tail.last = 1'b1;
      pixels_due.push_back(tail);
    end
  endtask

  // Sample all channels on the rising edge, before the block updates.
  always @(posedge clk) begin : monitor
    pixel_t due;
    if (rst) begin
      pixels_due.delete();
      draw_color     = 1'b0;
      mismatch_count = 0;
      lines_accepted = 0;
      pixels_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        draw_color = cfg_data;
      end
      if (start && !busy) begin
        rasterize_line(start_x, start_y, end_x, end_y);
        lines_accepted++;
      end
      if (pixel_valid) begin
        if (pixels_due.size() == 0) begin
          $error("pixel (%0d,%0d) arrived with no pixel due", pixel_x, pixel_y);
          mismatch_count++;
        end else begin
          due = pixels_due.pop_front();
          if (pixel_x !== due.x) begin
            $error("pixel_x: expected %0d, actual %0d", due.x, pixel_x);
            mismatch_count++;
          end
          if (pixel_y !== due.y) begin
            $error("pixel_y: expected %0d, actual %0d", due.y, pixel_y);
            mismatch_count++;
          end
          if (pixel_on !== due.on) begin
            $error("pixel_on: expected %0b, actual %0b", due.on, pixel_on);
            mismatch_count++;
          end
          if (last_pixel !== due.last) begin
            $error("last_pixel: expected %0b, actual %0b", due.last, last_pixel);
            mismatch_count++;
          end
          pixels_checked++;
        end
      end
    end
    pending_pixels = pixels_due.size();
  end

endmodule

// ===== tb/bresenham_line_rasterizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Drives directed and random line commands under both draw colors, with
// random pauses and back-to-back bursts, while a checker beside the block
// compares every emitted pixel with its own prediction.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_test;
  import blr_pkg::*;

  localparam int CLOCK_LIMIT      = 400000;
  localparam int LINES_PER_PHASE  = 70;
  localparam int SETTLE_CYCLES    = 10;

  logic   clk = 1'b0;
  logic   rst;
  logic   start;
  logic   busy;
  coord_t start_x, start_y, end_x, end_y;
  logic   cfg_valid;
  logic   cfg_ready;
  logic   cfg_data;
  logic   pixel_valid;
  coord_t pixel_x, pixel_y;
  logic   pixel_on;
  logic   last_pixel;

  int mismatch_count;
  int pending_pixels;
  int lines_accepted;
  int pixels_checked;
  int cycle_count = 0;

  bresenham_line_rasterizer dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_on    (pixel_on),
    .last_pixel  (last_pixel)
  );

  line_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_on       (pixel_on),
    .last_pixel     (last_pixel),
    .mismatch_count (mismatch_count),
    .pending_pixels (pending_pixels),
    .lines_accepted (lines_accepted),
    .pixels_checked (pixels_checked)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CLOCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One command transaction; returns at the edge that accepts it.
  task automatic send_line(input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    @(negedge clk);
    start   <= 1'b1;
    start_x <= sx;
    start_y <= sy;
    end_x   <= ex;
    end_y   <= ey;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off until every pixel due has come, then let the block settle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_color(input logic color);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Random line with a bias toward points, axis-aligned and short lines.
  task automatic random_line(output coord_t sx, output coord_t sy,
                             output coord_t ex, output coord_t ey);
    int r;
    r  = $urandom_range(0, 99);
    sx = coord_t'($urandom_range(0, 63));
    sy = coord_t'($urandom_range(0, 63));
    ex = coord_t'($urandom_range(0, 63));
    ey = coord_t'($urandom_range(0, 63));
    if (r < 8) begin
      ex = sx;
      ey = sy;
    end else if (r < 18) begin
      ex = sx;
    end else if (r < 28) begin
      ey = sy;
    end else if (r < 45) begin
      ex = sx ^ coord_t'($urandom_range(0, 7));
      ey = sy ^ coord_t'($urandom_range(0, 7));
    end
  endtask

  task automatic run_random(input int count, input bit back_to_back);
    coord_t sx, sy, ex, ey;
    for (int i = 0; i < count; i++) begin
      random_line(sx, sy, ex, ey);
      send_line(sx, sy, ex, ey);
      if (!back_to_back) pause(idle_cycles());
    end
  endtask

  // Field extremes, both axis-aligned orders, all four diagonals, shallow and steep lines, single points.
  task automatic run_directed();
    send_line(6'd0, 6'd0, 6'd0, 6'd0);
    send_line(6'd63, 6'd63, 6'd63, 6'd63);
    send_line(6'd0, 6'd0, 6'd0, 6'd63);
    send_line(6'd63, 6'd63, 6'd63, 6'd0);
    send_line(6'd5, 6'd60, 6'd5, 6'd3);
    send_line(6'd0, 6'd0, 6'd63, 6'd0);
    send_line(6'd63, 6'd63, 6'd0, 6'd63);
    send_line(6'd63, 6'd7, 6'd0, 6'd7);
    send_line(6'd0, 6'd0, 6'd63, 6'd63);
    send_line(6'd63, 6'd0, 6'd0, 6'd63);
    send_line(6'd0, 6'd63, 6'd63, 6'd0);
    send_line(6'd63, 6'd63, 6'd0, 6'd0);
    send_line(6'd0, 6'd0, 6'd63, 6'd1);
    send_line(6'd63, 6'd10, 6'd0, 6'd11);
    send_line(6'd0, 6'd0, 6'd1, 6'd63);
    send_line(6'd10, 6'd63, 6'd11, 6'd0);
    send_line(6'd20, 6'd5, 6'd10, 6'd50);
    send_line(6'd0, 6'd40, 6'd50, 6'd2);
    send_line(6'd1, 6'd1, 6'd4, 6'd2);
    send_line(6'd3, 6'd3, 6'd4, 6'd4);
    send_line(6'd3, 6'd3, 6'd4, 6'd3);
    send_line(6'd42, 6'd21, 6'd42, 6'd21);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    start_x   = '0;
    start_y   = '0;
    end_x     = '0;
    end_y     = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines with the reset color, then random phases that
    // alternate the color; one phase streams with no gaps at all.
    run_directed();
    drain();
    write_color(1'b1);
    run_random(LINES_PER_PHASE, 1'b0);
    drain();
    write_color(1'b0);
    run_random(LINES_PER_PHASE, 1'b1);
    drain();
    write_color(1'b1);
    run_random(LINES_PER_PHASE / 2, 1'b0);
    drain();
    run_random(LINES_PER_PHASE / 2, 1'b0);
    drain();
    write_color(1'b0);
    run_random(LINES_PER_PHASE, 1'b0);
    drain();

    $display("Drew %0d line commands, %0d pixels compared, under both draw colors.",
             lines_accepted, pixels_checked);
    $display("Stimulus mixed points, axis-aligned, short and long lines with random gaps.");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/blr_pkg.sv
design/blr_front.sv
design/blr_queue.sv
design/blr_back.sv
design/bresenham_line_rasterizer.sv
tb/line_pixel_checker.sv
tb/bresenham_line_rasterizer_test.sv
